>>> rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while reset is released.
`define CITA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cita assertion failed");

// Checked at every edge, reset included.
`define CITA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("cita reset assertion failed");

`endif

>>> rtl/cita_pkg.sv
`default_nettype none

package cita_pkg;

  localparam int AREA_W   = 35;
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_COINC = 2'd1,
    ST_APART = 2'd2
  } status_e;

  typedef struct packed {
    logic    vld;
    status_e st;
  } pair_ctl_t;

endpackage

`default_nettype wire

>>> rtl/cita_pair.sv
`default_nettype none

module cita_pair #(
  parameter int CW = 12,
  parameter int FB = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  logic signed [CW-1:0]   ax_i,
  input  logic signed [CW-1:0]   ay_i,
  input  logic [CW-1:0]          ar_i,
  input  logic signed [CW-1:0]   bx_i,
  input  logic signed [CW-1:0]   by_i,
  input  logic [CW-1:0]          br_i,
  input  logic signed [CW-1:0]   cx_i,
  input  logic signed [CW-1:0]   cy_i,
  input  logic [CW-1:0]          cr_i,
  output cita_pkg::pair_ctl_t    ctl_o,
  output logic signed [CW+FB+1:0] px_o,
  output logic signed [CW+FB+1:0] py_o
);
  import cita_pkg::*;

  localparam int DW  = CW + 1;
  localparam int D2W = 2 * CW + 1;
  localparam int R2W = 2 * CW;
  localparam int KW  = 2 * CW + 3;
  localparam int KXW = KW + DW;
  localparam int PRW = R2W + D2W;
  localparam int QSW = 4 * CW + 5;
  localparam int SW  = 2 * CW + 2 + FB;
  localparam int RW  = SW + 3;
  localparam int XW  = 2 * SW;
  localparam int SDW = SW + 1 + DW;
  localparam int NW  = 3 * CW + 5 + FB;
  localparam int QB  = CW + FB + 1;
  localparam int PW  = CW + FB + 2;
  localparam int UW  = CW + FB + 3;
  localparam int SQW = 2 * UW;
  localparam int LAT = SW + QB + 12;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic [CW-1:0]        cr;
  } geo_t;

  typedef struct packed {
    logic signed [KXW-1:0] kdx;
    logic signed [KXW-1:0] kdy;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic [D2W-1:0]        d2;
    geo_t                  geo;
    status_e               st;
  } sq_side_t;

  typedef struct packed {
    logic [D2W:0] div;
    logic [3:0]   neg;
    geo_t         geo;
    status_e      st;
  } dv_side_t;

  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[LAT-2:0], vld_i};
    end
  end

  // S1: center offsets, squared radii
  logic signed [DW-1:0] dx_q1, dy_q1;
  logic [R2W-1:0]       ra2_q1, rb2_q1, ra2_d1, rb2_d1;
  geo_t                 geo_q1;

  assign ra2_d1 = ar_i * ar_i;
  assign rb2_d1 = br_i * br_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q1  <= DW'(bx_i) - DW'(ax_i);
      dy_q1  <= DW'(by_i) - DW'(ay_i);
      ra2_q1 <= ra2_d1;
      rb2_q1 <= rb2_d1;
      geo_q1 <= '{ax: ax_i, ay: ay_i, cx: cx_i, cy: cy_i, cr: cr_i};
    end
  end

  // S2: squared distance
  logic signed [2*DW-1:0] dxx_d2, dyy_d2;
  logic signed [DW-1:0]   dx_q2, dy_q2;
  logic [D2W-1:0]         d2_q2;
  logic [R2W-1:0]         ra2_q2, rb2_q2;
  geo_t                   geo_q2;

  assign dxx_d2 = dx_q1 * dx_q1;
  assign dyy_d2 = dy_q1 * dy_q1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d2_q2  <= D2W'($unsigned(dxx_d2)) + D2W'($unsigned(dyy_d2));
      dx_q2  <= dx_q1;
      dy_q2  <= dy_q1;
      ra2_q2 <= ra2_q1;
      rb2_q2 <= rb2_q1;
      geo_q2 <= geo_q1;
    end
  end

  // S3: k and the ra2*d2 product (scaled by 4 in S5)
  logic signed [KW-1:0] k_q3;
  logic [PRW-1:0]       p_q3, p_d3;
  logic                 coinc_q3;
  logic signed [DW-1:0] dx_q3, dy_q3;
  logic [D2W-1:0]       d2_q3;
  geo_t                 geo_q3;

  assign p_d3 = ra2_q2 * d2_q2;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k_q3     <= $signed({3'b000, ra2_q2}) - $signed({3'b000, rb2_q2})
                  + $signed({2'b00, d2_q2});
      p_q3     <= p_d3;
      coinc_q3 <= (d2_q2 == '0);
      dx_q3    <= dx_q2;
      dy_q3    <= dy_q2;
      d2_q3    <= d2_q2;
      geo_q3   <= geo_q2;
    end
  end

  // S4: k squared, k*dx, k*dy
  logic signed [2*KW-1:0] k2_q4, k2_d4;
  logic signed [KXW-1:0]  kdx_q4, kdy_q4, kdx_d4, kdy_d4;
  logic [PRW-1:0]         p_q4;
  logic                   coinc_q4;
  logic signed [DW-1:0]   dx_q4, dy_q4;
  logic [D2W-1:0]         d2_q4;
  geo_t                   geo_q4;

  assign k2_d4  = k_q3 * k_q3;
  assign kdx_d4 = k_q3 * dx_q3;
  assign kdy_d4 = k_q3 * dy_q3;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k2_q4    <= k2_d4;
      kdx_q4   <= kdx_d4;
      kdy_q4   <= kdy_d4;
      p_q4     <= p_q3;
      coinc_q4 <= coinc_q3;
      dx_q4    <= dx_q3;
      dy_q4    <= dy_q3;
      d2_q4    <= d2_q3;
      geo_q4   <= geo_q3;
    end
  end

  // S5: discriminant, classification, root radicand
  logic signed [QSW-1:0] q_d5;
  logic                  apart_d5;
  status_e               st_d5;

  assign q_d5     = $signed({2'b00, p_q4, 2'b00}) - $signed(k2_q4[QSW-1:0]);
  assign apart_d5 = q_d5[QSW-1];

  always_comb begin
    if (coinc_q4) begin
      st_d5 = ST_COINC;
    end else if (apart_d5) begin
      st_d5 = ST_APART;
    end else begin
      st_d5 = ST_OK;
    end
  end

  // Square root, one result bit per stage
  logic [XW-1:0] rad_q  [SW];
  logic [RW-1:0] rem_q  [SW];
  logic [SW-1:0] root_q [SW+1];
  sq_side_t      sqs_q  [SW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q[0]  <= apart_d5 ? '0
                   : XW'({q_d5[QSW-3:0], {(2*FB){1'b0}}});
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      sqs_q[0]  <= '{kdx: kdx_q4, kdy: kdy_q4, dx: dx_q4, dy: dy_q4,
                     d2: d2_q4, geo: geo_q4, st: st_d5};
    end
  end

  for (genvar g = 0; g < SW; g++) begin : g_sqrt
    logic [RW-1:0] remsh, trial;
    logic          ge;

    assign remsh = {rem_q[g][RW-3:0], rad_q[g][XW-1 -: 2]};
    assign trial = {1'b0, root_q[g], 2'b01};
    assign ge    = (remsh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[g+1] <= {root_q[g][SW-2:0], ge};
        sqs_q[g+1]  <= sqs_q[g];
      end
    end

    if (g < SW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[g+1] <= ge ? (remsh - trial) : remsh;
          rad_q[g+1] <= {rad_q[g][XW-3:0], 2'b00};
        end
      end
    end
  end

  // NA: root times offsets
  logic signed [SDW-1:0] sdy_qa, sdx_qa, sdy_da, sdx_da;
  logic signed [KXW-1:0] kdx_qa, kdy_qa;
  logic [D2W-1:0]        d2_qa;
  geo_t                  geo_qa;
  status_e               st_qa;

  assign sdy_da = $signed({1'b0, root_q[SW]}) * sqs_q[SW].dy;
  assign sdx_da = $signed({1'b0, root_q[SW]}) * sqs_q[SW].dx;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sdy_qa <= sdy_da;
      sdx_qa <= sdx_da;
      kdx_qa <= sqs_q[SW].kdx;
      kdy_qa <= sqs_q[SW].kdy;
      d2_qa  <= sqs_q[SW].d2;
      geo_qa <= sqs_q[SW].geo;
      st_qa  <= sqs_q[SW].st;
    end
  end

  // NB: four numerators, lanes x1 x2 y1 y2
  logic signed [NW-1:0] kxf_b, kyf_b;
  logic signed [NW-1:0] n_qb [4];
  logic [D2W-1:0]       d2_qb;
  geo_t                 geo_qb;
  status_e              st_qb;

  assign kxf_b = NW'(kdx_qa) <<< FB;
  assign kyf_b = NW'(kdy_qa) <<< FB;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_qb[0] <= kxf_b + NW'(sdy_qa);
      n_qb[1] <= kxf_b - NW'(sdy_qa);
      n_qb[2] <= kyf_b - NW'(sdx_qa);
      n_qb[3] <= kyf_b + NW'(sdx_qa);
      d2_qb   <= d2_qa;
      geo_qb  <= geo_qa;
      st_qb   <= st_qa;
    end
  end

  // Rounded division by 2*d2, one quotient bit per stage
  logic [NW-1:0] drem_q [QB][4];
  logic [QB-1:0] quo_q  [QB+1][4];
  dv_side_t      dvs_q  [QB+1];
  logic [3:0]    neg_c;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [NW-1:0] mag;

    assign neg_c[l] = n_qb[l][NW-1];
    assign mag      = neg_c[l] ? $unsigned(-n_qb[l]) : $unsigned(n_qb[l]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        drem_q[0][l] <= mag + NW'(d2_qb);
        quo_q[0][l]  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvs_q[0] <= '{div: {d2_qb, 1'b0}, neg: neg_c, geo: geo_qb, st: st_qb};
    end
  end

  for (genvar g = 0; g < QB; g++) begin : g_div
    localparam int SH = QB - 1 - g;
    logic [NW-1:0] dsh;

    assign dsh = NW'(dvs_q[g].div) << SH;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvs_q[g+1] <= dvs_q[g];
      end
    end

    for (genvar l = 0; l < 4; l++) begin : g_dlane
      logic ge;

      assign ge = (drem_q[g][l] >= dsh);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo_q[g+1][l] <= {quo_q[g][l][QB-2:0], ge};
        end
      end

      if (g < QB - 1) begin : g_rem
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            drem_q[g+1][l] <= ge ? (drem_q[g][l] - dsh) : drem_q[g][l];
          end
        end
      end
    end
  end

  // P1: both candidate points
  logic signed [PW-1:0] off_w [4];
  logic signed [PW-1:0] axf_w, ayf_w;
  logic signed [PW-1:0] bx1_q1, by1_q1, bx2_q1, by2_q1;
  geo_t                 geo_p1;
  status_e              st_p1;

  for (genvar l = 0; l < 4; l++) begin : g_off
    assign off_w[l] = dvs_q[QB].neg[l] ? -$signed({1'b0, quo_q[QB][l]})
                      : $signed({1'b0, quo_q[QB][l]});
  end

  assign axf_w = PW'($signed({dvs_q[QB].geo.ax, {FB{1'b0}}}));
  assign ayf_w = PW'($signed({dvs_q[QB].geo.ay, {FB{1'b0}}}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bx1_q1 <= axf_w + off_w[0];
      bx2_q1 <= axf_w + off_w[1];
      by1_q1 <= ayf_w + off_w[2];
      by2_q1 <= ayf_w + off_w[3];
      geo_p1 <= dvs_q[QB].geo;
      st_p1  <= dvs_q[QB].st;
    end
  end

  // P2: first candidate relative to third center
  logic signed [UW-1:0] ux_q2, uy_q2;
  logic [R2W-1:0]       rr_q2, rr_d2;
  logic signed [PW-1:0] bx1_q2, by1_q2, bx2_q2, by2_q2;
  status_e              st_p2;

  assign rr_d2 = geo_p1.cr * geo_p1.cr;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux_q2  <= UW'(bx1_q1) - UW'($signed({geo_p1.cx, {FB{1'b0}}}));
      uy_q2  <= UW'(by1_q1) - UW'($signed({geo_p1.cy, {FB{1'b0}}}));
      rr_q2  <= rr_d2;
      bx1_q2 <= bx1_q1;
      by1_q2 <= by1_q1;
      bx2_q2 <= bx2_q1;
      by2_q2 <= by2_q1;
      st_p2  <= st_p1;
    end
  end

  // P3: squared distance to third center
  logic signed [2*UW-1:0] uxx_d3, uyy_d3;
  logic [SQW-1:0]         sq_q3;
  logic [R2W-1:0]         rr_q3;
  logic signed [PW-1:0]   bx1_q3, by1_q3, bx2_q3, by2_q3;
  status_e                st_p3;

  assign uxx_d3 = ux_q2 * ux_q2;
  assign uyy_d3 = uy_q2 * uy_q2;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q3  <= SQW'($unsigned(uxx_d3)) + SQW'($unsigned(uyy_d3));
      rr_q3  <= rr_q2;
      bx1_q3 <= bx1_q2;
      by1_q3 <= by1_q2;
      bx2_q3 <= bx2_q2;
      by2_q3 <= by2_q2;
      st_p3  <= st_p2;
    end
  end

  // P4: keep first candidate when strictly inside third circle
  logic                 keep_d4;
  logic signed [PW-1:0] px_q, py_q;
  status_e              st_q;

  assign keep_d4 = (sq_q3 < SQW'({rr_q3, {(2*FB){1'b0}}}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= keep_d4 ? bx1_q3 : bx2_q3;
      py_q <= keep_d4 ? by1_q3 : by2_q3;
      st_q <= st_p3;
    end
  end

  assign px_o      = px_q;
  assign py_o      = py_q;
  assign ctl_o.vld = vld_q[LAT-1];
  assign ctl_o.st  = st_q;

endmodule

`default_nettype wire

>>> rtl/circle_intersection_triangle_area_unit.sv
// Three-circle intersection triangle area. Each input beat carries three circles; for each
// cyclic pair the unit picks the meeting point lying strictly inside the remaining circle
// (else its mirror) and returns the absolute triangle area with FRAC_BITS fraction bits,
// rounded half up and saturated at 2^35-1. Status 1 flags coincident centers, 2 a pair
// that does not meet; both force the area to zero and 1 wins over 2. The unit is fully
// pipelined and takes one beat per clock while the output is not stalled; each pair lane holds
// a bit-per-stage square root and a bit-per-stage rounding divider. A stalled output freezes
// the whole pipeline.
`default_nettype none
`include "assert_macros.svh"

module circle_intersection_triangle_area_unit #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [COORD_BITS-1:0]        first_cx_i,
  input  logic signed [COORD_BITS-1:0]        first_cy_i,
  input  logic [COORD_BITS-1:0]               first_rad_i,
  input  logic signed [COORD_BITS-1:0]        second_cx_i,
  input  logic signed [COORD_BITS-1:0]        second_cy_i,
  input  logic [COORD_BITS-1:0]               second_rad_i,
  input  logic signed [COORD_BITS-1:0]        third_cx_i,
  input  logic signed [COORD_BITS-1:0]        third_cy_i,
  input  logic [COORD_BITS-1:0]               third_rad_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [cita_pkg::AREA_W-1:0]         tri_area_o,
  output logic [cita_pkg::STATUS_W-1:0]       status_o
);
  import cita_pkg::*;

  localparam int PW  = COORD_BITS + FRAC_BITS + 2;
  localparam int PW1 = PW + 1;
  localparam int PDW = PW + PW1;
  localparam int SMW = PDW + 2;
  localparam int EW  = (SMW > AREA_W) ? SMW : AREA_W;

  logic en;
  logic out_vld_q;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  pair_ctl_t            ctl_p [3];
  logic signed [PW-1:0] px_w  [3];
  logic signed [PW-1:0] py_w  [3];

  cita_pair #(.CW(COORD_BITS), .FB(FRAC_BITS)) u_pair0 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i),
    .ax_i(first_cx_i),  .ay_i(first_cy_i),  .ar_i(first_rad_i),
    .bx_i(second_cx_i), .by_i(second_cy_i), .br_i(second_rad_i),
    .cx_i(third_cx_i),  .cy_i(third_cy_i),  .cr_i(third_rad_i),
    .ctl_o(ctl_p[0]), .px_o(px_w[0]), .py_o(py_w[0])
  );

  cita_pair #(.CW(COORD_BITS), .FB(FRAC_BITS)) u_pair1 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i),
    .ax_i(second_cx_i), .ay_i(second_cy_i), .ar_i(second_rad_i),
    .bx_i(third_cx_i),  .by_i(third_cy_i),  .br_i(third_rad_i),
    .cx_i(first_cx_i),  .cy_i(first_cy_i),  .cr_i(first_rad_i),
    .ctl_o(ctl_p[1]), .px_o(px_w[1]), .py_o(py_w[1])
  );

  cita_pair #(.CW(COORD_BITS), .FB(FRAC_BITS)) u_pair2 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i),
    .ax_i(third_cx_i),  .ay_i(third_cy_i),  .ar_i(third_rad_i),
    .bx_i(first_cx_i),  .by_i(first_cy_i),  .br_i(first_rad_i),
    .cx_i(second_cx_i), .cy_i(second_cy_i), .cr_i(second_rad_i),
    .ctl_o(ctl_p[2]), .px_o(px_w[2]), .py_o(py_w[2])
  );

  // Valid chain for the area stages
  logic [2:0] tvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvld_q    <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      tvld_q    <= {tvld_q[1:0], ctl_p[0].vld & ctl_p[1].vld & ctl_p[2].vld};
      out_vld_q <= tvld_q[2];
    end
  end

  // T1: status merge, y differences
  status_e              st_d1, st_q1, st_q2, st_q3, st_q;
  logic                 any_coinc, any_apart;
  logic signed [PW-1:0] xs_q  [3];
  logic signed [PW1-1:0] ydf_q [3];

  assign any_coinc = (ctl_p[0].st == ST_COINC) || (ctl_p[1].st == ST_COINC)
                     || (ctl_p[2].st == ST_COINC);
  assign any_apart = (ctl_p[0].st == ST_APART) || (ctl_p[1].st == ST_APART)
                     || (ctl_p[2].st == ST_APART);

  always_comb begin
    if (any_coinc) begin
      st_d1 = ST_COINC;
    end else if (any_apart) begin
      st_d1 = ST_APART;
    end else begin
      st_d1 = ST_OK;
    end
  end

  // T2: cross products
  logic signed [PDW-1:0] prod_q [3];

  for (genvar i = 0; i < 3; i++) begin : g_tri
    localparam int J1 = (i + 1) % 3;
    localparam int J2 = (i + 2) % 3;
    logic signed [PDW-1:0] prod_d;

    assign prod_d = xs_q[i] * ydf_q[i];

    always_ff @(posedge clk_i) begin
      if (en) begin
        xs_q[i]   <= px_w[i];
        ydf_q[i]  <= PW1'(py_w[J1]) - PW1'(py_w[J2]);
        prod_q[i] <= prod_d;
      end
    end
  end

  // T3: signed double area
  logic signed [SMW-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q1 <= st_d1;
      st_q2 <= st_q1;
      st_q3 <= st_q2;
      sum_q <= SMW'(prod_q[0]) + SMW'(prod_q[1]) + SMW'(prod_q[2]);
    end
  end

  // T4: half magnitude, rounding, saturation
  logic [SMW-1:0]    mag_w, half_w;
  logic [EW-1:0]     half_x;
  logic [AREA_W-1:0] area_d, area_q;

  assign mag_w  = sum_q[SMW-1] ? $unsigned(-sum_q) : $unsigned(sum_q);
  assign half_w = (mag_w + (SMW'(1) << FRAC_BITS)) >> (FRAC_BITS + 1);
  assign half_x = EW'(half_w);

  always_comb begin
    if (st_q3 != ST_OK) begin
      area_d = '0;
    end else if (half_x > EW'({AREA_W{1'b1}})) begin
      area_d = '1;
    end else begin
      area_d = half_x[AREA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      area_q <= area_d;
      st_q   <= st_q3;
    end
  end

  assign out_valid_o = out_vld_q;
  assign tri_area_o  = area_q;
  assign status_o    = st_q;

  `CITA_ASSERT(a_err_zero, out_valid_o && (status_o != ST_OK) |-> (tri_area_o == '0))
  `CITA_ASSERT(a_lane_sync, (ctl_p[0].vld == ctl_p[1].vld) && (ctl_p[1].vld == ctl_p[2].vld))
  `CITA_ASSERT(a_stall_hold, !en |=> $stable(tvld_q) && out_vld_q)
  `CITA_ASSERT_RST(a_rst_clear, !rst_ni |=> !out_valid_o)

endmodule

`default_nettype wire

>>> bench/cita_checker.sv
`default_nettype none

module cita_checker #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_ready_i,
  input  wire logic signed [COORD_BITS-1:0]  first_cx_i,
  input  wire logic signed [COORD_BITS-1:0]  first_cy_i,
  input  wire logic [COORD_BITS-1:0]         first_rad_i,
  input  wire logic signed [COORD_BITS-1:0]  second_cx_i,
  input  wire logic signed [COORD_BITS-1:0]  second_cy_i,
  input  wire logic [COORD_BITS-1:0]         second_rad_i,
  input  wire logic signed [COORD_BITS-1:0]  third_cx_i,
  input  wire logic signed [COORD_BITS-1:0]  third_cy_i,
  input  wire logic [COORD_BITS-1:0]         third_rad_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_ready_i,
  input  wire logic [cita_pkg::AREA_W-1:0]   tri_area_i,
  input  wire logic [cita_pkg::STATUS_W-1:0] status_i,
  output int                                 fail_cnt_o,
  output int                                 pending_o
);
  import cita_pkg::*;

  typedef struct {
    logic [AREA_W-1:0] area;
    status_e           st;
  } area_res_t;

  area_res_t area_q[$];

  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam longint AREA_MAX = (longint'(1) << AREA_W) - 1;

  function automatic longint unsigned scaled_isqrt(longint unsigned q);
    longint unsigned root, rem, trial, pr;
    root = 0;
    rem = 0;
    for (int i = 31 + FRAC_BITS; i >= 0; i--) begin
      pr = (i >= FRAC_BITS) ? ((q >> (2 * (i - FRAC_BITS))) & 64'd3) : 64'd0;
      rem = (rem << 2) | pr;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint div_round(longint n, longint h);
    longint unsigned mag, qv;
    mag = (n < 0) ? longint'(-n) : n;
    qv = (mag + longint'(h)) / (2 * longint'(h));
    return (n < 0) ? -longint'(qv) : longint'(qv);
  endfunction

  // point where circles a and b meet, chosen against circle c
  function automatic status_e meet_point(longint ax, longint ay, longint ar,
                                         longint bx, longint by, longint br,
                                         longint cx, longint cy, longint cr,
                                         output longint px, output longint py);
    longint dx, dy, d2, ra2, k, q, s, ux, uy;
    dx = bx - ax;
    dy = by - ay;
    d2 = dx * dx + dy * dy;
    px = 0;
    py = 0;
    if (d2 == 0) return ST_COINC;
    ra2 = ar * ar;
    k = ra2 - br * br + d2;
    q = 4 * ra2 * d2 - k * k;
    if (q < 0) return ST_APART;
    s = longint'(scaled_isqrt(q));
    px = ax * ONE + div_round(k * dx * ONE + s * dy, d2);
    py = ay * ONE + div_round(k * dy * ONE - s * dx, d2);
    ux = px - cx * ONE;
    uy = py - cy * ONE;
    if (ux * ux + uy * uy >= cr * cr * ONE * ONE) begin
      px = ax * ONE + div_round(k * dx * ONE - s * dy, d2);
      py = ay * ONE + div_round(k * dy * ONE + s * dx, d2);
    end
    return ST_OK;
  endfunction

  function automatic area_res_t triangle_area(longint cxs[3], longint cys[3],
                                              longint rs[3]);
    area_res_t res;
    longint px[3], py[3], sum;
    longint unsigned mag, ar;
    status_e st, pst;
    st = ST_OK;
    for (int j = 0; j < 3; j++) begin
      pst = meet_point(cxs[j], cys[j], rs[j], cxs[(j+1)%3], cys[(j+1)%3], rs[(j+1)%3],
                       cxs[(j+2)%3], cys[(j+2)%3], rs[(j+2)%3], px[j], py[j]);
      if (pst == ST_COINC) st = ST_COINC;
      else if (pst == ST_APART && st == ST_OK) st = ST_APART;
    end
    res.st = st;
    res.area = '0;
    if (st != ST_OK) return res;
    sum = 0;
    for (int j = 0; j < 3; j++)
      sum += px[j] * py[(j+1)%3] - px[j] * py[(j+2)%3];
    mag = (sum < 0) ? longint'(-sum) : sum;
    ar = (mag + longint'(ONE)) >> (FRAC_BITS + 1);
    if (ar > AREA_MAX) ar = AREA_MAX;
    res.area = ar[AREA_W-1:0];
    return res;
  endfunction

  area_res_t want;
  longint cxs[3], cys[3], rs[3];

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_i) begin
      cxs[0] = longint'(first_cx_i);  cys[0] = longint'(first_cy_i);
      rs[0] = longint'({1'b0, first_rad_i});
      cxs[1] = longint'(second_cx_i); cys[1] = longint'(second_cy_i);
      rs[1] = longint'({1'b0, second_rad_i});
      cxs[2] = longint'(third_cx_i);  cys[2] = longint'(third_cy_i);
      rs[2] = longint'({1'b0, third_rad_i});
      area_q.insert(area_q.size(), triangle_area(cxs, cys, rs));
    end
    if (rst_ni && out_valid_i && out_ready_i) begin
      if (area_q.size() == 0) begin
        $display("%0t: unexpected beat area=%0d status=%0d", $time, tri_area_i, status_i);
        fail_cnt_o++;
      end else begin
        want = area_q.pop_front();
        if (tri_area_i !== want.area) begin
          $display("%0t: tri_area expected %0d actual %0d", $time, want.area, tri_area_i);
          fail_cnt_o++;
        end
        if (status_i !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status_i);
          fail_cnt_o++;
        end
      end
    end
    pending_o <= area_q.size();
  end

  initial begin
    fail_cnt_o = 0;
    pending_o = 0;
  end
endmodule

`default_nettype wire

>>> bench/tb.sv
`default_nettype none

module tb;
  import cita_pkg::*;

  localparam int CB = 12;
  localparam int FB = 8;
  localparam int N_RAND = 1400;
  localparam int WD_LIMIT = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CB-1:0] c_x[3], c_y[3];
  logic [CB-1:0] c_r[3];
  logic out_valid;
  logic out_ready = 1'b0;
  logic [AREA_W-1:0] tri_area;
  logic [STATUS_W-1:0] status;
  int fail_cnt, pending;
  bit quiet = 1'b0;
  int stall_cyc = 0;

  always #6 clk_i = ~clk_i;

  initial begin
    for (int j = 0; j < 3; j++) begin
      c_x[j] = '0; c_y[j] = '0; c_r[j] = '0;
    end
  end

  circle_intersection_triangle_area_unit #(.COORD_BITS(CB), .FRAC_BITS(FB)) DUT (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_ready_o(in_ready),
    .first_cx_i(c_x[0]), .first_cy_i(c_y[0]), .first_rad_i(c_r[0]),
    .second_cx_i(c_x[1]), .second_cy_i(c_y[1]), .second_rad_i(c_r[1]),
    .third_cx_i(c_x[2]), .third_cy_i(c_y[2]), .third_rad_i(c_r[2]),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .tri_area_o(tri_area), .status_o(status)
  );

  cita_checker #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_checker (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_ready_i(in_ready),
    .first_cx_i(c_x[0]), .first_cy_i(c_y[0]), .first_rad_i(c_r[0]),
    .second_cx_i(c_x[1]), .second_cy_i(c_y[1]), .second_rad_i(c_r[1]),
    .third_cx_i(c_x[2]), .third_cy_i(c_y[2]), .third_rad_i(c_r[2]),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .tri_area_i(tri_area), .status_i(status),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // sink side stalls in bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (stall_cyc > 0) begin
      stall_cyc <= stall_cyc - 1;
      out_ready <= (stall_cyc == 1);
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_cyc <= $urandom_range(1, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  int idle_cyc = 0;
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WD_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_beat(input int x0, y0, r0, x1, y1, r1, x2, y2, r2);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    c_x[0] <= CB'(x0); c_y[0] <= CB'(y0); c_r[0] <= CB'(r0);
    c_x[1] <= CB'(x1); c_y[1] <= CB'(y1); c_r[1] <= CB'(r1);
    c_x[2] <= CB'(x2); c_y[2] <= CB'(y2); c_r[2] <= CB'(r2);
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  function automatic int pick_c(int s);
    int v;
    v = $urandom_range(0, 2 * s) - s;
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return v;
  endfunction

  function automatic int pick_r(int s);
    int v;
    v = $urandom_range(s / 2 + 1, 2 * s + 2);
    return (v > 4095) ? 4095 : v;
  endfunction

  int sc;
  int wt;

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_beat(0, 0, 5, 6, 0, 5, 3, 4, 5);
    send_beat(0, 0, 5, 0, 0, 5, 3, 4, 5);            // coincident, equal radii
    send_beat(0, 0, 1, 100, 0, 1, 50, 50, 3);        // apart
    send_beat(0, 0, 1, 0, 0, 2, 500, 500, 1);        // coincident and apart
    send_beat(0, 0, 3, 5, 0, 2, 3, 0, 4);            // touching
    send_beat(0, 0, 5, 4, 0, 1, 2, 2, 3);            // internal touching
    send_beat(-2048, -2048, 4095, 2047, 2047, 4095, 2047, -2048, 4095);
    send_beat(-2048, 2047, 4095, 2047, -2048, 4095, -2048, -2048, 4095);
    send_beat(0, 0, 0, 1, 0, 1, 0, 1, 1);
    send_beat(0, 0, 4095, 1, 1, 4095, -1, 1, 4095);
    send_beat(-2048, 0, 2048, 2047, 0, 2048, 0, 2047, 2900);
    send_beat(10, 10, 0, 10, 10, 0, 10, 10, 0);
    send_beat(-1, -1, 4095, 0, 0, 0, 1, 1, 4094);
    send_beat(100, 0, 60, -100, 0, 60, 0, 0, 10);
    send_beat(0, 0, 2, 3, 0, 2, 1, 1, 1);

    for (int i = 0; i < N_RAND; i++) begin
      if (i > N_RAND - 150) quiet = 1'b1;
      if ($urandom_range(0, 9) < 2) begin
        send_beat($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
      end else begin
        case ($urandom_range(0, 3))
          0: sc = $urandom_range(2, 16);
          1: sc = $urandom_range(16, 128);
          2: sc = $urandom_range(128, 1024);
          default: sc = $urandom_range(1024, 2047);
        endcase
        send_beat(pick_c(sc), pick_c(sc), pick_r(sc), pick_c(sc), pick_c(sc), pick_r(sc),
                  pick_c(sc), pick_c(sc), pick_r(sc));
      end
    end
    in_valid <= 1'b0;

    wt = 0;
    while ((pending != 0 || out_valid) && wt < 20000) begin
      @(posedge clk_i);
      wt++;
    end
    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
